// ===== src/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Shared sizes, character codes, status codes and bracket classification.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Stack geometry.
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW         = $clog2(STACK_DEPTH + 1);

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned LINE_W   = 24;
  localparam int unsigned COL_W    = 16;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd4;

  // Bracket kinds.
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRACE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd3;

  // Result of one byte, as handed to the output register.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   expected;
    logic [DEPTH_W-1:0]  depth;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    col;
  } result_t;

  // Checker state visible to the top level.
  typedef struct packed {
    logic           halted;
    logic [SPW-1:0] sp;
  } state_t;

  function automatic logic [KIND_W-1:0] opener_kind(input logic [BYTE_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_LPAREN:  k = KIND_PAREN;
      CH_LBRACE:  k = KIND_BRACE;
      CH_LSQUARE: k = KIND_SQUARE;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] closer_kind(input logic [BYTE_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_RPAREN:  k = KIND_PAREN;
      CH_RBRACE:  k = KIND_BRACE;
      CH_RSQUARE: k = KIND_SQUARE;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/bbc_stack_ram.sv =====
// ----------------------------------------------------------------------------
// Bracket stack memory
// One write port, one registered read port, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module bbc_stack_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bbc_pkg::AW-1:0]      waddr_i,
  input  logic [bbc_pkg::KIND_W-1:0]  wdata_i,
  input  logic [bbc_pkg::AW-1:0]      raddr_i,
  output logic [bbc_pkg::KIND_W-1:0]  rdata_o
);
  import bbc_pkg::*;

  logic [KIND_W-1:0] mem [STACK_DEPTH];
  logic [KIND_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A write and a read of the same entry in one cycle return the new data.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bracket checker control
// Classifies each byte, keeps the top of stack, stack pointer, sticky error
// and text position, and drives the stack memory.
// ----------------------------------------------------------------------------
module bbc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bbc_pkg::BYTE_W-1:0]  text_byte_i,
  output bbc_pkg::result_t            result_o,
  output bbc_pkg::state_t             state_o
);
  import bbc_pkg::*;

  logic [SPW-1:0]    sp_q, sp_d;
  logic [KIND_W-1:0] top_q, top_d;
  logic              halted_q, halted_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;

  logic [KIND_W-1:0] ok_kind, ck_kind, below_top;
  logic              full, empty, push, pop;
  logic [STATUS_W-1:0] status;
  logic [KIND_W-1:0]   expected;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;

  // The memory holds every entry below the top; its read port always
  // prefetches the entry just below the top for the next pop.
  bbc_stack_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (top_q),
    .raddr_i (ram_raddr),
    .rdata_o (below_top)
  );

  assign ok_kind = opener_kind(text_byte_i);
  assign ck_kind = closer_kind(text_byte_i);
  assign full    = (sp_q == SPW'(STACK_DEPTH));
  assign empty   = (sp_q == '0);

  always_comb begin
    status   = ST_OK;
    expected = KIND_NONE;
    push     = 1'b0;
    pop      = 1'b0;
    if (halted_q) begin
      status = ST_STOPPED;
    end else if (ok_kind != KIND_NONE) begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        push = 1'b1;
      end
    end else if (ck_kind != KIND_NONE) begin
      if (empty) begin
        status = ST_NO_OPEN;
      end else if (top_q != ck_kind) begin
        status   = ST_MISMATCH;
        expected = top_q;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (!halted_q) begin
      if (text_byte_i == CH_NEWLINE) begin
        if (line_q != LINE_MAX) begin
          line_d = line_q + LINE_W'(1);
        end
        col_d = '0;
      end else if (col_q != COL_MAX) begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    sp_d     = sp_q;
    top_d    = top_q;
    halted_d = halted_q;
    if (step_i) begin
      if (push) begin
        sp_d  = sp_q + SPW'(1);
        top_d = ok_kind;
      end else if (pop) begin
        sp_d  = sp_q - SPW'(1);
        top_d = below_top;
      end
      if (status != ST_OK) begin
        halted_d = 1'b1;
      end
    end
  end

  // The old top spills into the memory only when a push lands on a non-empty stack.
  assign ram_we    = step_i && push && !empty;
  assign ram_waddr = AW'(sp_q - SPW'(1));
  assign ram_raddr = AW'(sp_d - SPW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      halted_q <= 1'b0;
      line_q   <= '0;
      col_q    <= '0;
    end else if (step_i) begin
      sp_q     <= sp_d;
      halted_q <= halted_d;
      line_q   <= line_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_comb begin
    result_o.status   = status;
    result_o.expected = expected;
    result_o.depth    = DEPTH_W'(sp_d);
    result_o.line     = line_d;
    result_o.col      = col_d;
  end

  assign state_o.halted = halted_q;
  assign state_o.sp     = sp_q;

endmodule

// ===== src/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker
// Checks ( { [ nesting over a byte stream and reports position and errors.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o | text_byte_i
//   out     | out_valid_o/out_ready_i | status_o, expected_kind_o,
//           |                         | nesting_depth_o, line_number_o,
//           |                         | column_number_o
//
// One beat is accepted per cycle while the output is not stalled; its result is registered.
// The top of stack sits in a register and the stack memory prefetches the
// entry below it, so a push or pop completes in the cycle of its beat.
// Reset leaves the stack empty; no clearing pass is needed.
// A stalled output holds its beat; a new input beat is taken in the same
// cycle as the output beat drains.
// ----------------------------------------------------------------------------
module bracket_balance_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbc_pkg::BYTE_W-1:0]    text_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbc_pkg::STATUS_W-1:0]  status_o,
  output logic [bbc_pkg::KIND_W-1:0]    expected_kind_o,
  output logic [bbc_pkg::DEPTH_W-1:0]   nesting_depth_o,
  output logic [bbc_pkg::LINE_W-1:0]    line_number_o,
  output logic [bbc_pkg::COL_W-1:0]     column_number_o
);
  import bbc_pkg::*;

  logic    in_fire;
  logic    out_valid_q;
  result_t result, result_q;
  state_t  state;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .text_byte_i (text_byte_i),
    .result_o    (result),
    .state_o     (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = result_q.status;
  assign expected_kind_o = result_q.expected;
  assign nesting_depth_o = result_q.depth;
  assign line_number_o   = result_q.line;
  assign column_number_o = result_q.col;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.halted |=> state.halted)
    else $error("error state cleared without reset");

  a_halt_reports_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state.halted |=> out_valid_q && (result_q.status == ST_STOPPED))
    else $error("beat after error not reported as stopped");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !state.halted && (result.status != ST_OK) |=> state.halted)
    else $error("error beat did not stop the checker");

endmodule

// ===== verif/bracket_balance_checker_tb.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker testbench
// Streams text bytes into the checker with random gaps and output stalls.
// A local bracket tracker predicts every result beat. The stream opens with a
// short table of edge bytes. Random well-formed nested text follows, with
// noise, and the run ends with one randomly chosen error and a few bytes
// after the halt.
// ----------------------------------------------------------------------------
module bracket_balance_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_200_000;
  localparam int unsigned RANDOM_BEATS = 1400;
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 300;
  localparam int unsigned PRINT_CAP    = 40;

  typedef enum int unsigned {TAIL_NO_OPEN, TAIL_MISMATCH, TAIL_OVERFLOW} tail_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              typed;
    result_t           want;
  } table_row_t;

  typedef struct {
    logic [BYTE_W-1:0] text;
    bit                typed;
    result_t           want;
    bit                calm;
  } text_beat_t;

  localparam result_t NO_EXP = '0;

  // Rows with typed values are checked against those; the rest go through the
  // tracker. The first rows push three kinds, cross a newline and pop them.
  localparam table_row_t EDGE_ROWS [23] = '{
    {8'h00,      1'b1, ST_OK, KIND_NONE, 7'd0, 24'd0, 16'd1},
    {8'hFF,      1'b1, ST_OK, KIND_NONE, 7'd0, 24'd0, 16'd2},
    {CH_LPAREN,  1'b1, ST_OK, KIND_NONE, 7'd1, 24'd0, 16'd3},
    {CH_LBRACE,  1'b0, NO_EXP},
    {CH_LSQUARE, 1'b0, NO_EXP},
    {CH_NEWLINE, 1'b1, ST_OK, KIND_NONE, 7'd3, 24'd1, 16'd0},
    {CH_RSQUARE, 1'b0, NO_EXP},
    {CH_RBRACE,  1'b0, NO_EXP},
    {CH_RPAREN,  1'b1, ST_OK, KIND_NONE, 7'd0, 24'd1, 16'd3},
    {8'h7F,      1'b0, NO_EXP},
    {8'h80,      1'b0, NO_EXP},
    {8'h01,      1'b0, NO_EXP},
    {8'hFE,      1'b0, NO_EXP},
    {8'h27,      1'b0, NO_EXP},
    {8'h2A,      1'b0, NO_EXP},
    {8'h7C,      1'b0, NO_EXP},
    {8'h7E,      1'b0, NO_EXP},
    {8'h5C,      1'b0, NO_EXP},
    {8'h5E,      1'b0, NO_EXP},
    {8'h09,      1'b0, NO_EXP},
    {8'h0B,      1'b0, NO_EXP},
    {8'h0D,      1'b0, NO_EXP},
    {CH_NEWLINE, 1'b1, ST_OK, KIND_NONE, 7'd0, 24'd2, 16'd0}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   text_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [KIND_W-1:0]   out_kind;
  logic [DEPTH_W-1:0]  out_depth;
  logic [LINE_W-1:0]   out_line;
  logic [COL_W-1:0]    out_col;

  // Tracker state.
  logic [KIND_W-1:0] open_kinds [STACK_DEPTH];
  int unsigned       open_count = 0;
  logic [LINE_W-1:0] cur_line   = '0;
  logic [COL_W-1:0]  cur_col    = '0;
  bit                stopped    = 1'b0;

  result_t           pending_results [$];
  text_beat_t        text_stream [$];
  logic [KIND_W-1:0] gen_kinds [$];

  bit          stream_ready   = 1'b0;
  bit          send_done      = 1'b0;
  bit          calm_now       = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;

  bracket_balance_checker DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .text_byte_i     (text_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (out_status),
    .expected_kind_o (out_kind),
    .nesting_depth_o (out_depth),
    .line_number_o   (out_line),
    .column_number_o (out_col)
  );

  always #6 clk = ~clk;

  function automatic result_t track_brackets(input logic [BYTE_W-1:0] c);
    result_t           r;
    logic [KIND_W-1:0] opn;
    logic [KIND_W-1:0] cls;
    r.status   = ST_OK;
    r.expected = KIND_NONE;
    opn = KIND_NONE;
    cls = KIND_NONE;
    case (c)
      CH_LPAREN:  opn = KIND_PAREN;
      CH_LBRACE:  opn = KIND_BRACE;
      CH_LSQUARE: opn = KIND_SQUARE;
      CH_RPAREN:  cls = KIND_PAREN;
      CH_RBRACE:  cls = KIND_BRACE;
      CH_RSQUARE: cls = KIND_SQUARE;
      default: ;
    endcase
    if (stopped) begin
      r.status = ST_STOPPED;
    end else begin
      // The position moves first, so an error points at the offending byte.
      if (c == CH_NEWLINE) begin
        if (cur_line != LINE_MAX) cur_line++;
        cur_col = '0;
      end else if (cur_col != COL_MAX) begin
        cur_col++;
      end
      if (opn != KIND_NONE) begin
        if (open_count >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
          stopped  = 1'b1;
        end else begin
          open_kinds[open_count] = opn;
          open_count++;
        end
      end else if (cls != KIND_NONE) begin
        if (open_count == 0) begin
          r.status = ST_NO_OPEN;
          stopped  = 1'b1;
        end else if (open_kinds[open_count-1] != cls) begin
          r.status   = ST_MISMATCH;
          r.expected = open_kinds[open_count-1];
          stopped    = 1'b1;
        end else begin
          open_count--;
        end
      end
    end
    r.depth = DEPTH_W'(open_count);
    r.line  = cur_line;
    r.col   = cur_col;
    return r;
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic bit is_bracket(input logic [BYTE_W-1:0] c);
    return c inside {CH_LPAREN, CH_LBRACE, CH_LSQUARE, CH_RPAREN, CH_RBRACE, CH_RSQUARE};
  endfunction

  function automatic logic [BYTE_W-1:0] opener_of(input logic [KIND_W-1:0] k);
    case (k)
      KIND_PAREN: return CH_LPAREN;
      KIND_BRACE: return CH_LBRACE;
      default:    return CH_LSQUARE;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] closer_of(input logic [KIND_W-1:0] k);
    case (k)
      KIND_PAREN: return CH_RPAREN;
      KIND_BRACE: return CH_RBRACE;
      default:    return CH_RSQUARE;
    endcase
  endfunction

  // Any byte that is neither a bracket nor a newline, with a newline one time
  // in nl_odds (never when nl_odds is zero).
  function automatic logic [BYTE_W-1:0] plain_char(input int unsigned nl_odds);
    logic [BYTE_W-1:0] c;
    if (nl_odds != 0 && $urandom_range(nl_odds - 1, 0) == 0) return CH_NEWLINE;
    do c = BYTE_W'($urandom_range(255, 0)); while (is_bracket(c) || c == CH_NEWLINE);
    return c;
  endfunction

  task automatic put(input logic [BYTE_W-1:0] c, input bit calm);
    text_beat_t t;
    t.text  = c;
    t.typed = 1'b0;
    t.want  = NO_EXP;
    t.calm  = calm;
    text_stream = {text_stream, t};
  endtask

  task automatic gen_open(input bit calm);
    logic [KIND_W-1:0] k;
    k = KIND_W'($urandom_range(3, 1));
    gen_kinds = {gen_kinds, k};
    put(opener_of(k), calm);
  endtask

  task automatic gen_close(input bit calm);
    logic [KIND_W-1:0] k;
    k = gen_kinds[$];
    gen_kinds.delete(gen_kinds.size() - 1);
    put(closer_of(k), calm);
  endtask

  task automatic close_all(input bit calm);
    while (gen_kinds.size() > 0) begin
      if ($urandom_range(3, 0) == 0) put(plain_char(10), calm);
      gen_close(calm);
    end
  endtask

  task automatic gen_nested(input bit calm);
    int unsigned limit;
    int unsigned r;
    limit = ($urandom_range(9, 0) == 0) ? STACK_DEPTH : $urandom_range(8, 1);
    repeat ($urandom_range(40, 4)) begin
      r = $urandom_range(9, 0);
      if (r < 3 && gen_kinds.size() < limit) gen_open(calm);
      else if (r < 6 && gen_kinds.size() > 0) gen_close(calm);
      else put(plain_char(10), calm);
    end
    close_all(calm);
  endtask

  // Fills the stack exactly to its depth, then empties it.
  task automatic gen_deep(input bit calm);
    repeat (STACK_DEPTH) begin
      if ($urandom_range(3, 0) == 0) put(plain_char(10), calm);
      gen_open(calm);
    end
    close_all(calm);
  endtask

  task automatic gen_error_tail();
    tail_kind_e        pick;
    logic [KIND_W-1:0] top;
    logic [KIND_W-1:0] wrong;
    pick = tail_kind_e'($urandom_range(2, 0));
    case (pick)
      TAIL_NO_OPEN: put(closer_of(KIND_W'($urandom_range(3, 1))), 1'b0);
      TAIL_MISMATCH: begin
        repeat ($urandom_range(3, 1)) gen_open(1'b0);
        top   = gen_kinds[$];
        wrong = KIND_W'((top - 1 + $urandom_range(2, 1)) % 3 + 1);
        put(closer_of(wrong), 1'b0);
      end
      default: begin
        repeat (STACK_DEPTH) gen_open(1'b0);
        put(opener_of(KIND_W'($urandom_range(3, 1))), 1'b0);
      end
    endcase
    // Everything after the error must come back as stopped.
    repeat ($urandom_range(12, 4)) put(BYTE_W'($urandom_range(255, 0)), 1'b0);
  endtask

  task automatic report_mismatch(input string field, input longint unsigned seen,
                                 input longint unsigned want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch on %s at result %0d: got %0d, want %0d",
               field, results_seen, seen, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected beat", out_status, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_status !== want.status)   report_mismatch("status", out_status, want.status);
      if (out_kind !== want.expected)   report_mismatch("expected_kind", out_kind, want.expected);
      if (out_depth !== want.depth)     report_mismatch("nesting_depth", out_depth, want.depth);
      if (out_line !== want.line)       report_mismatch("line_number", out_line, want.line);
      if (out_col !== want.col)         report_mismatch("column_number", out_col, want.col);
    end
    results_seen++;
  endtask

  initial begin : build_and_judge
    text_beat_t  t;
    int unsigned mark;
    int unsigned random_count;
    int unsigned sel;
    bit          calm;
    random_count = 0;
    foreach (EDGE_ROWS[i]) begin
      t.text  = EDGE_ROWS[i].text;
      t.typed = EDGE_ROWS[i].typed;
      t.want  = EDGE_ROWS[i].want;
      t.calm  = 1'b0;
      text_stream = {text_stream, t};
    end
    while (random_count < RANDOM_BEATS) begin
      mark = text_stream.size();
      calm = ($urandom_range(4, 0) == 0);
      sel  = $urandom_range(9, 0);
      if (sel < 7) gen_nested(calm);
      else if (sel < 8) gen_deep(calm);
      else repeat ($urandom_range(30, 5)) put(plain_char(4), calm);
      random_count += text_stream.size() - mark;
    end
    gen_error_tail();
    stream_ready = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (send_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : feed_text
    int unsigned idx;
    int unsigned gap;
    result_t     predicted;
    wait (stream_ready);
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (idx = 0; idx < text_stream.size(); idx++) begin
      calm_now = text_stream[idx].calm;
      gap = calm_now ? 0 : pick_idle();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      text_byte <= text_stream[idx].text;
      do @(posedge clk); while (!in_ready);
      predicted = track_brackets(text_stream[idx].text);
      if (text_stream[idx].typed) predicted = text_stream[idx].want;
      pending_results = {pending_results, predicted};
    end
    in_valid <= 1'b0;
    send_done = 1'b1;
  end

  initial begin : drain_results
    int unsigned hold_left;
    int unsigned n;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready) check_result();
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
        // Long hold while the sender keeps offering, so the input backs up.
        pressure_done = 1'b1;
        hold_left     = PRESSURE_LEN - 1;
        out_ready <= 1'b0;
      end else if (!calm_now && $urandom_range(3, 0) == 0) begin
        n = pick_idle();
        if (n != 0) begin
          hold_left = n - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
